### hw/rtl/prime_field_alu_core_defines.svh
// Assertion macros used by the prime field ALU controller.
`ifndef PRIME_FIELD_ALU_CORE_DEFINES_SVH
`define PRIME_FIELD_ALU_CORE_DEFINES_SVH

// Same-cycle implication, switched off while reset is high.
`define PFA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define PFA_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/pfa_pkg.sv
// Types and constants shared by the prime field ALU modules.
package pfa_pkg;

  localparam int DATA_W = 30;
  localparam int EXP_W  = 63;
  localparam int KIND_W = 3;
  localparam int SGN_W  = 32;
  localparam int RED_W  = 32;
  localparam int PROD_W = 2 * DATA_W;
  localparam int Q1_W   = DATA_W + 1;
  localparam int Q2_W   = Q1_W + RED_W;

  // Operation codes.
  localparam logic [KIND_W-1:0] KIND_ADD = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SUB = 3'd1;
  localparam logic [KIND_W-1:0] KIND_MUL = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DIV = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NEG = 3'd4;
  localparam logic [KIND_W-1:0] KIND_INV = 3'd5;
  localparam logic [KIND_W-1:0] KIND_POW = 3'd6;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] operand_a;
    logic [DATA_W-1:0] operand_b;
    logic [EXP_W-1:0]  exponent;
  } pfa_in_t;

  typedef struct packed {
    logic [DATA_W-1:0] result_value;
    logic              range_error;
  } pfa_out_t;

  // Operand pairs for the modular multiplier.
  typedef enum logic [1:0] {
    MSEL_AB,
    MSEL_ARES,
    MSEL_ACC_SQ,
    MSEL_SQ_SQ
  } pfa_mul_sel_t;

  // Register that takes the multiplier's product.
  typedef enum logic [1:0] {
    DEST_NONE,
    DEST_RES,
    DEST_ACC,
    DEST_SQ
  } pfa_mul_dest_t;

  typedef struct packed {
    logic          load;
    logic          simple_op;
    logic          mul_start;
    pfa_mul_sel_t  mul_sel;
    pfa_mul_dest_t mul_dest;
    logic          euc_init;
    logic          div_start;
    logic          div_capture;
    logic          euc_update;
    logic          inv_finish;
    logic          pow_init;
    logic          pow_shift;
    logic          pow_finish;
  } pfa_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              range_err;
    logic              r1_zero;
    logic              e_zero;
    logic              e_lsb;
    logic              mul_done;
    logic              div_done;
  } pfa_status_t;

endpackage

### hw/rtl/prime_field_alu_core.sv
// Top level of the prime field ALU: controller plus datapath.
// Add, sub, neg, an unused kind or a range error finish from the decode state; mul runs one multiply.
// Inverse and div run extended Euclid, one step per divide in the radix-2 divider;
// div ends with one 5-stage Barrett multiply.
// Pow squares, and multiplies where the bit is set, for each exponent bit up to its highest set bit.
// Next beat taken the cycle after the result beat, which cannot stall; sync reset idles.
module prime_field_alu_core #(
  parameter int unsigned MODULUS = 1000000007
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  pfa_pkg::pfa_in_t  request,
  output logic              done,
  output pfa_pkg::pfa_out_t response
);
  import pfa_pkg::*;

  pfa_cmd_t    cmd;
  pfa_status_t status;

  pfa_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .cmd    (cmd),
    .status (status)
  );

  pfa_datapath #(
    .MODULUS (MODULUS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .request  (request),
    .cmd      (cmd),
    .status   (status),
    .response (response)
  );

endmodule

### hw/rtl/pfa_modmul.sv
// Five-stage pipelined modular multiplier using Barrett reduction.
module pfa_modmul #(
  parameter int unsigned MODULUS = 1000000007
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [pfa_pkg::DATA_W-1:0] op_a,
  input  logic [pfa_pkg::DATA_W-1:0] op_b,
  output logic                      done,
  output logic [pfa_pkg::DATA_W-1:0] product
);
  import pfa_pkg::*;

  // Barrett constants: the modulus fits in N bits, MU = floor(4^N / MODULUS).
  localparam int          N       = $clog2(MODULUS + 1);
  localparam logic [63:0] MU_FULL = (64'd1 << (2 * N)) / 64'(MODULUS);
  localparam logic [RED_W-1:0] MU  = MU_FULL[RED_W-1:0];
  localparam logic [RED_W-1:0] M1  = RED_W'(MODULUS);
  localparam logic [RED_W-1:0] M2  = RED_W'(2 * MODULUS);

  logic [4:0]        vld;
  logic [PROD_W-1:0] x1;
  logic [Q2_W-1:0]   q2;
  logic [RED_W-1:0]  x2;
  logic [RED_W-1:0]  x3;
  logic [RED_W-1:0]  qm;
  logic [RED_W-1:0]  r4;

  logic [PROD_W-1:0] x1_sh;
  logic [Q1_W-1:0]   q1;
  logic [Q2_W-1:0]   q2_sh;
  logic [DATA_W-1:0] q3;
  logic [PROD_W-1:0] qm_full;
  logic [RED_W-1:0]  r_fix;

  // Quotient estimate and its back-multiplication.
  assign x1_sh   = x1 >> (N - 1);
  assign q1      = x1_sh[Q1_W-1:0];
  assign q2_sh   = q2 >> (N + 1);
  assign q3      = q2_sh[DATA_W-1:0];
  assign qm_full = PROD_W'(q3) * PROD_W'(MODULUS);

  // The estimate is at most two short, so the residue stays below three moduli.
  always_comb begin
    if (r4 >= M2) begin
      r_fix = r4 - M2;
    end else if (r4 >= M1) begin
      r_fix = r4 - M1;
    end else begin
      r_fix = r4;
    end
  end

  // Stage valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[3:0], start};
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    x1      <= PROD_W'(op_a) * PROD_W'(op_b);
    q2      <= Q2_W'(q1) * Q2_W'(MU);
    x2      <= x1[RED_W-1:0];
    qm      <= qm_full[RED_W-1:0];
    x3      <= x2;
    r4      <= x3 - qm;
    product <= r_fix[DATA_W-1:0];
  end

  assign done = vld[4];

endmodule

### hw/rtl/pfa_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module pfa_divider (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [pfa_pkg::DATA_W-1:0] dividend,
  input  logic [pfa_pkg::DATA_W-1:0] divisor,
  output logic                       done,
  output logic [pfa_pkg::DATA_W-1:0] quotient,
  output logic [pfa_pkg::DATA_W-1:0] remainder
);
  import pfa_pkg::*;

  localparam int CW = $clog2(DATA_W);

  logic              running;
  logic [CW-1:0]     cnt;
  logic [DATA_W-1:0] dvs;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] quo;

  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;
  logic              ge;

  // Shift the next dividend bit into the partial remainder and try a subtraction.
  assign trial = {rem, quo[DATA_W-1]};
  assign ge    = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};

  // Sequencing flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
      end else if (running && (cnt == CW'(DATA_W - 1))) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  // Quotient and remainder registers.
  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= '0;
      dvs <= divisor;
      rem <= '0;
      quo <= dividend;
    end else if (running) begin
      cnt <= cnt + 1'b1;
      rem <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      quo <= {quo[DATA_W-2:0], ge};
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

### hw/rtl/pfa_datapath.sv
// Operand, Euclid and power registers with the shared arithmetic units.
module pfa_datapath #(
  parameter int unsigned MODULUS = 1000000007
) (
  input  logic                 clk,
  input  logic                 rst,
  input  pfa_pkg::pfa_in_t     request,
  input  pfa_pkg::pfa_cmd_t    cmd,
  output pfa_pkg::pfa_status_t status,
  output pfa_pkg::pfa_out_t    response
);
  import pfa_pkg::*;

  localparam logic [DATA_W-1:0]       MOD_W = DATA_W'(MODULUS);
  localparam logic [DATA_W:0]         MOD_X = (DATA_W + 1)'(MODULUS);
  localparam logic signed [SGN_W-1:0] MOD_S = SGN_W'(MODULUS);

  // Captured item.
  logic [KIND_W-1:0] kind;
  logic [DATA_W-1:0] op_a;
  logic [DATA_W-1:0] op_b;
  logic [EXP_W-1:0]  expo;
  logic              err;
  logic [DATA_W-1:0] res;

  // Power and Euclid state.
  logic [DATA_W-1:0]       acc;
  logic [DATA_W-1:0]       sq;
  logic [DATA_W-1:0]       r0;
  logic [DATA_W-1:0]       r1;
  logic [DATA_W-1:0]       rem_q;
  logic signed [SGN_W-1:0] s0;
  logic signed [SGN_W-1:0] s1;
  logic signed [SGN_W-1:0] qs;

  logic              err_next;
  logic [DATA_W:0]   sum;
  logic [DATA_W:0]   dif;
  logic [DATA_W-1:0] add_res;
  logic [DATA_W-1:0] sub_res;
  logic [DATA_W-1:0] neg_res;
  logic [DATA_W-1:0] simple_res;
  logic [DATA_W-1:0] inv_norm;
  logic signed [SGN_W-1:0]   inv_tmp;
  logic signed [2*SGN_W-1:0] qs_full;

  logic [DATA_W-1:0] mul_a;
  logic [DATA_W-1:0] mul_b;
  logic              mul_done;
  logic [DATA_W-1:0] mul_prod;
  logic              div_done;
  logic [DATA_W-1:0] div_quo;
  logic [DATA_W-1:0] div_rem;

  // Range check on the incoming beat: b counts only for the two-operand kinds.
  assign err_next = (request.kind <= KIND_POW) &&
                    ((request.operand_a >= MOD_W) ||
                     ((request.kind <= KIND_DIV) && (request.operand_b >= MOD_W)));

  // Combinational add, sub and neg.
  assign sum     = {1'b0, op_a} + {1'b0, op_b};
  assign dif     = {1'b0, op_a} + (MOD_X - {1'b0, op_b});
  assign add_res = (sum >= MOD_X) ? DATA_W'(sum - MOD_X) : sum[DATA_W-1:0];
  assign sub_res = (dif >= MOD_X) ? DATA_W'(dif - MOD_X) : dif[DATA_W-1:0];
  assign neg_res = (op_a == '0) ? '0 : MOD_W - op_a;

  always_comb begin
    simple_res = '0;
    if (!err) begin
      case (kind)
        KIND_ADD: simple_res = add_res;
        KIND_SUB: simple_res = sub_res;
        KIND_NEG: simple_res = neg_res;
        default:  simple_res = '0;
      endcase
    end
  end

  // Bring the final Bezout coefficient into the range of residues.
  always_comb begin
    if (s0 < 0) begin
      inv_tmp = s0 + MOD_S;
    end else if (s0 >= MOD_S) begin
      inv_tmp = s0 - MOD_S;
    end else begin
      inv_tmp = s0;
    end
  end
  assign inv_norm = inv_tmp[DATA_W-1:0];

  // Quotient times coefficient for the Euclid update.
  assign qs_full = $signed({2'b00, div_quo}) * s1;

  // Multiplier operand selection.
  always_comb begin
    case (cmd.mul_sel)
      MSEL_AB: begin
        mul_a = op_a;
        mul_b = op_b;
      end
      MSEL_ARES: begin
        mul_a = op_a;
        mul_b = res;
      end
      MSEL_ACC_SQ: begin
        mul_a = acc;
        mul_b = sq;
      end
      MSEL_SQ_SQ: begin
        mul_a = sq;
        mul_b = sq;
      end
      default: begin
        mul_a = op_a;
        mul_b = op_b;
      end
    endcase
  end

  pfa_modmul #(
    .MODULUS (MODULUS)
  ) u_modmul (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.mul_start),
    .op_a    (mul_a),
    .op_b    (mul_b),
    .done    (mul_done),
    .product (mul_prod)
  );

  pfa_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (r0),
    .divisor   (r1),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Register updates under controller command.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind <= request.kind;
      op_a <= request.operand_a;
      op_b <= request.operand_b;
      expo <= request.exponent;
      err  <= err_next;
    end
    if (cmd.simple_op) begin
      res <= simple_res;
    end
    if (cmd.euc_init) begin
      r0 <= (kind == KIND_DIV) ? op_b : op_a;
      r1 <= MOD_W;
      s0 <= SGN_W'(1);
      s1 <= '0;
    end
    if (cmd.div_capture) begin
      qs    <= qs_full[SGN_W-1:0];
      rem_q <= div_rem;
    end
    if (cmd.euc_update) begin
      r0 <= r1;
      r1 <= rem_q;
      s0 <= s1;
      s1 <= s0 - qs;
    end
    if (cmd.inv_finish) begin
      res <= inv_norm;
    end
    if (cmd.pow_init) begin
      acc <= DATA_W'(1);
      sq  <= op_a;
    end
    if (cmd.pow_shift) begin
      expo <= expo >> 1;
    end
    if (cmd.pow_finish) begin
      res <= acc;
    end
    if (mul_done) begin
      case (cmd.mul_dest)
        DEST_RES: res <= mul_prod;
        DEST_ACC: acc <= mul_prod;
        DEST_SQ:  sq  <= mul_prod;
        default:  ;
      endcase
    end
  end

  // Status towards the controller.
  assign status.kind      = kind;
  assign status.range_err = err;
  assign status.r1_zero   = (r1 == '0);
  assign status.e_zero    = (expo == '0);
  assign status.e_lsb     = expo[0];
  assign status.mul_done  = mul_done;
  assign status.div_done  = div_done;

  assign response.result_value = res;
  assign response.range_error  = err;

endmodule

### hw/rtl/pfa_ctrl.sv
// Sequencer for the prime field ALU operations.
`include "prime_field_alu_core_defines.svh"

module pfa_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  output logic                 done,
  output pfa_pkg::pfa_cmd_t    cmd,
  input  pfa_pkg::pfa_status_t status
);
  import pfa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_MUL_RES,
    S_EUC_TEST,
    S_EUC_DIV,
    S_EUC_UPD,
    S_EUC_FIN,
    S_DIV_MUL,
    S_POW_TEST,
    S_POW_ACC,
    S_POW_SQ,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.mul_sel  = MSEL_AB;
    cmd.mul_dest = DEST_NONE;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (status.range_err) begin
          cmd.simple_op = 1'b1;
          state_next    = S_DONE;
        end else begin
          case (status.kind)
            KIND_MUL: begin
              cmd.mul_start = 1'b1;
              cmd.mul_sel   = MSEL_AB;
              state_next    = S_MUL_RES;
            end
            KIND_DIV, KIND_INV: begin
              cmd.euc_init = 1'b1;
              state_next   = S_EUC_TEST;
            end
            KIND_POW: begin
              cmd.pow_init = 1'b1;
              state_next   = S_POW_TEST;
            end
            default: begin
              cmd.simple_op = 1'b1;
              state_next    = S_DONE;
            end
          endcase
        end
      end
      S_MUL_RES: begin
        cmd.mul_dest = DEST_RES;
        if (status.mul_done) begin
          state_next = S_DONE;
        end
      end
      S_EUC_TEST: begin
        if (status.r1_zero) begin
          state_next = S_EUC_FIN;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_EUC_DIV;
        end
      end
      S_EUC_DIV: begin
        if (status.div_done) begin
          cmd.div_capture = 1'b1;
          state_next      = S_EUC_UPD;
        end
      end
      S_EUC_UPD: begin
        cmd.euc_update = 1'b1;
        state_next     = S_EUC_TEST;
      end
      S_EUC_FIN: begin
        cmd.inv_finish = 1'b1;
        state_next     = (status.kind == KIND_DIV) ? S_DIV_MUL : S_DONE;
      end
      S_DIV_MUL: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MSEL_ARES;
        state_next    = S_MUL_RES;
      end
      S_POW_TEST: begin
        if (status.e_zero) begin
          cmd.pow_finish = 1'b1;
          state_next     = S_DONE;
        end else if (status.e_lsb) begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = MSEL_ACC_SQ;
          state_next    = S_POW_ACC;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = MSEL_SQ_SQ;
          state_next    = S_POW_SQ;
        end
      end
      S_POW_ACC: begin
        // The square does not depend on the accumulator, so it issues on completion.
        cmd.mul_dest = DEST_ACC;
        if (status.mul_done) begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = MSEL_SQ_SQ;
          state_next    = S_POW_SQ;
        end
      end
      S_POW_SQ: begin
        cmd.mul_dest = DEST_SQ;
        if (status.mul_done) begin
          cmd.pow_shift = 1'b1;
          state_next    = S_POW_TEST;
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

  // Checks on sequencing.
  `PFA_ASSERT_NXT(a_done_then_idle, clk, rst, done, !busy, "result beat not followed by idle")
  `PFA_ASSERT_NXT(a_accept_busy, clk, rst, start && !busy, busy, "accepted beat left block idle")
  `PFA_ASSERT_IMP(a_mul_expected, clk, rst, status.mul_done, (state == S_MUL_RES) || (state == S_POW_ACC) || (state == S_POW_SQ), "product arrived outside a wait state")
  `PFA_ASSERT_IMP(a_div_expected, clk, rst, status.div_done, state == S_EUC_DIV, "quotient arrived outside the divide wait")

endmodule
